@@ hdl/ipv4v_pkg.sv @@
package ipv4v_pkg;

  // character codes
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharColon = 8'h3A;

  // limits of the parts
  localparam int unsigned PartW    = 17;
  localparam int unsigned ProdW    = 21;
  localparam logic [PartW-1:0] OctetMax = 17'd255;
  localparam logic [PartW-1:0] PortMax  = 17'd65535;
  localparam logic [PartW-1:0] AccSat   = 17'd65536;

  // part index: octets a..d are 0..3, the port is 4
  localparam logic [2:0] LastOctetIdx = 3'd3;
  localparam logic [2:0] PortIdx      = 3'd4;

  // one result word
  typedef struct packed {
    logic        ok;
    logic [31:0] address;
    logic [15:0] port;
  } result_t;

endpackage

@@ hdl/ipv4v_parser.sv @@
module ipv4v_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic [7:0]           char_code_i,
  input  logic                 last_char_i,
  output ipv4v_pkg::result_t   res_o
);

  logic [2:0]                       part_index_q, part_index_d;
  logic [ipv4v_pkg::PartW-1:0]      part_value_q, part_value_d;
  logic                             digit_seen_q, digit_seen_d;
  logic                             zero_first_q, zero_first_d;
  logic                             error_q, error_d;
  logic [31:0]                      octets_q, octets_d;

  logic                             is_digit;
  logic                             is_dot;
  logic                             is_colon;
  logic [3:0]                       digit;
  logic [ipv4v_pkg::ProdW-1:0]      prod;
  logic                             pos_ok;
  logic                             ok;

  // character classes and the decimal step
  always_comb begin
    is_digit = (char_code_i >= ipv4v_pkg::CharZero) && (char_code_i <= ipv4v_pkg::CharNine);
    is_dot   = (char_code_i == ipv4v_pkg::CharDot);
    is_colon = (char_code_i == ipv4v_pkg::CharColon);
    digit    = 4'(char_code_i - ipv4v_pkg::CharZero);
    prod     = {part_value_q, 3'b000} + {2'b00, part_value_q, 1'b0}
               + ipv4v_pkg::ProdW'(digit);
    pos_ok   = is_dot ? (part_index_q < ipv4v_pkg::LastOctetIdx)
                      : (part_index_q == ipv4v_pkg::LastOctetIdx);
  end

  // parse one character
  always_comb begin
    part_index_d = part_index_q;
    part_value_d = part_value_q;
    digit_seen_d = digit_seen_q;
    zero_first_d = zero_first_q;
    error_d      = error_q;
    octets_d     = octets_q;
    if (!error_q) begin
      if (is_digit) begin
        if (digit_seen_q && zero_first_q) begin
          error_d = 1'b1;
        end else begin
          if (!digit_seen_q && digit == 4'd0) begin
            zero_first_d = 1'b1;
          end
          digit_seen_d = 1'b1;
          if (prod > ipv4v_pkg::ProdW'(ipv4v_pkg::PortMax)) begin
            part_value_d = ipv4v_pkg::AccSat;
            error_d      = 1'b1;
          end else begin
            part_value_d = prod[ipv4v_pkg::PartW-1:0];
          end
        end
      end else if (is_dot || is_colon) begin
        if (!pos_ok || !digit_seen_q || part_value_q > ipv4v_pkg::OctetMax) begin
          error_d = 1'b1;
        end else begin
          octets_d     = {octets_q[23:0], part_value_q[7:0]};
          part_index_d = part_index_q + 3'd1;
          part_value_d = '0;
          digit_seen_d = 1'b0;
          zero_first_d = 1'b0;
        end
      end else begin
        error_d = 1'b1;
      end
    end
  end

  // result of a text ending with this character
  always_comb begin
    ok = !error_d && (part_index_d == ipv4v_pkg::PortIdx) && digit_seen_d
         && (part_value_d <= ipv4v_pkg::PortMax);
    res_o.ok      = ok;
    res_o.address = ok ? octets_d : 32'd0;
    res_o.port    = ok ? part_value_d[15:0] : 16'd0;
  end

  // parser state, back to reset after the last character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_index_q <= '0;
      part_value_q <= '0;
      digit_seen_q <= 1'b0;
      zero_first_q <= 1'b0;
      error_q      <= 1'b0;
      octets_q     <= '0;
    end else if (fire_i) begin
      if (last_char_i) begin
        part_index_q <= '0;
        part_value_q <= '0;
        digit_seen_q <= 1'b0;
        zero_first_q <= 1'b0;
        error_q      <= 1'b0;
        octets_q     <= '0;
      end else begin
        part_index_q <= part_index_d;
        part_value_q <= part_value_d;
        digit_seen_q <= digit_seen_d;
        zero_first_q <= zero_first_d;
        error_q      <= error_d;
        octets_q     <= octets_d;
      end
    end
  end

endmodule

@@ hdl/ipv4v_out_reg.sv @@
module ipv4v_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  ipv4v_pkg::result_t   res_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic                 valid_res_o,
  output logic [31:0]          address_o,
  output logic [15:0]          port_o
);

  logic                out_valid_q, out_valid_d;
  ipv4v_pkg::result_t  res_q;

  // word held until the receiver takes it
  always_comb begin
    if (load_i) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign valid_res_o = res_q.ok;
  assign address_o   = res_q.address;
  assign port_o      = res_q.port;

endmodule

@@ hdl/ipv4v_core_top.sv @@
// ipv4_port_text_validator_core: checks a text "a.b.c.d:p" fed one character per word.
// Input channel: in_valid_i / in_stall_o with char_code_i and last_char_i, where
// last_char_i marks the final character of a text. Output channel: out_valid_o /
// out_stall_i with valid_res_o, address_o (first octet in bits 31..24) and port_o;
// address and port read 0 when the text is malformed. One output word is given per
// text, after its last character; other characters give none.
// A character waits in the input register and is then parsed into the parser state or,
// for a last character, into the result register, whose word is then valid.
// Throughput: one character per cycle while the sender is not stalled, set by the
// parser, which takes the held character whenever it is not blocked.
// While the receiver stalls, a finished word waits in the result register and
// characters keep flowing; only a further last character waits in the input
// register, which then stalls the sender.
// Reset clears the parser state and both valid flags; the block is ready at once.
module ipv4_port_text_validator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        valid_res_o,
  output logic [31:0] address_o,
  output logic [15:0] port_o
);

  logic               in_valid_q, in_valid_d;
  logic [7:0]         char_q;
  logic               last_q;
  logic               blocked;
  logic               fire;
  logic               in_fire;
  ipv4v_pkg::result_t res;

  // the held character moves on unless it ends a text and the result slot is full
  assign blocked    = in_valid_q && last_q && out_valid_o && out_stall_i;
  assign fire       = in_valid_q && !blocked;
  assign in_stall_o = blocked;
  assign in_fire    = in_valid_i && !in_stall_o;

  // input register
  always_comb begin
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      char_q <= char_code_i;
      last_q <= last_char_i;
    end
  end

  // parser
  ipv4v_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .char_code_i (char_q),
    .last_char_i (last_q),
    .res_o       (res)
  );

  // result register
  ipv4v_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire && last_q),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .valid_res_o (valid_res_o),
    .address_o   (address_o),
    .port_o      (port_o)
  );

  // a malformed text reports zero address and port
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> address_o == 32'd0 && port_o == 16'd0)
    else $error("invalid result carries nonzero fields");

  // the sender is only stalled behind a full, stalled result slot
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i && in_valid_q && last_q)
    else $error("input stalled without a full result slot");

  // a parsed last character always yields a result word
  a_last_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && last_q |=> out_valid_o)
    else $error("last character produced no result");

  // a non-last character never creates a word
  a_no_spurious_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !(fire && last_q) |=> !out_valid_o)
    else $error("result word without a last character");

endmodule

@@ bench/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomChars = 1600;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned NumCases    = 18;

  localparam ipv4v_pkg::result_t Rejected = '0;

  typedef enum int unsigned {StallNone, StallHalf, StallMost, StallAll} stall_mode_e;
  typedef enum int unsigned {TextClean, TextMutated, TextOverflow, TextSoup, TextNoise} text_kind_e;
  typedef enum int unsigned {MutReplace, MutDelete, MutInsert, MutLeadZero} mutation_e;

  typedef struct {
    string              text;
    bit                 typed;
    ipv4v_pkg::result_t want;
  } text_case_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  char_code_i = '0;
  logic        last_char_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        valid_res_o;
  logic [31:0] address_o;
  logic [15:0] port_o;

  ipv4_port_text_validator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .valid_res_o (valid_res_o),
    .address_o   (address_o),
    .port_o      (port_o)
  );

  always #6 clk_i = ~clk_i;

  // parser state of the predictor
  logic [2:0]                  prs_idx = '0;
  logic [ipv4v_pkg::PartW-1:0] prs_val = '0;
  logic                        prs_digit = 1'b0;
  logic                        prs_zero = 1'b0;
  logic                        prs_err = 1'b0;
  logic [31:0]                 prs_octets = '0;

  ipv4v_pkg::result_t pending_results[$];
  logic [7:0]  text_chars[$];
  int unsigned mismatches = 0;
  int unsigned chars_sent = 0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;

  // directed texts: expectations typed in where they are obvious
  text_case_t text_cases[NumCases] = '{
    '{"0.0.0.0:0",             1'b1, '{1'b1, 32'h0000_0000, 16'h0000}},
    '{"255.255.255.255:65535", 1'b1, '{1'b1, 32'hFFFF_FFFF, 16'hFFFF}},
    '{"10.1.200.7:8080",       1'b0, Rejected},
    '{"01.2.3.4:5",            1'b1, Rejected},
    '{"1.2.3.4:007",           1'b1, Rejected},
    '{"256.1.1.1:1",           1'b1, Rejected},
    '{"1.2.3.4:65536",         1'b1, Rejected},
    '{"9999999",               1'b1, Rejected},
    '{"1..2.3:4",              1'b1, Rejected},
    '{"1.2.3.4.5:6",           1'b1, Rejected},
    '{"1.2:3.4:5",             1'b1, Rejected},
    '{"1.2.3.4:",              1'b1, Rejected},
    '{"1.2.3.4",               1'b1, Rejected},
    '{"a.b.c.d:p",             1'b1, Rejected},
    '{"1.2.3.4:8x",            1'b1, Rejected},
    '{"1.2.3.4:5:6",           1'b1, Rejected},
    '{":",                     1'b1, Rejected},
    '{"0.99.100.0:0",          1'b0, Rejected}
  };

  // one character into the parser; returns 1 when a word is due
  function automatic bit parse_char(input logic [7:0] c, input logic last,
                                    output ipv4v_pkg::result_t res);
    logic [ipv4v_pkg::ProdW-1:0] acc;
    logic [7:0]                  digit;
    bit                          sep_ok;
    res = Rejected;
    if (!prs_err) begin
      if (c >= ipv4v_pkg::CharZero && c <= ipv4v_pkg::CharNine) begin
        digit = c - ipv4v_pkg::CharZero;
        if (prs_digit && prs_zero) begin
          prs_err = 1'b1;
        end else begin
          if (!prs_digit && digit == 8'd0) prs_zero = 1'b1;
          prs_digit = 1'b1;
          acc = ipv4v_pkg::ProdW'(prs_val * 10 + digit);
          if (acc > ipv4v_pkg::PortMax) begin
            prs_val = ipv4v_pkg::AccSat;
            prs_err = 1'b1;
          end else begin
            prs_val = acc[ipv4v_pkg::PartW-1:0];
          end
        end
      end else if (c == ipv4v_pkg::CharDot || c == ipv4v_pkg::CharColon) begin
        sep_ok = (c == ipv4v_pkg::CharDot) ? (prs_idx < ipv4v_pkg::LastOctetIdx)
                                           : (prs_idx == ipv4v_pkg::LastOctetIdx);
        if (!sep_ok || !prs_digit || prs_val > ipv4v_pkg::OctetMax) begin
          prs_err = 1'b1;
        end else begin
          prs_octets = {prs_octets[23:0], prs_val[7:0]};
          prs_idx    = prs_idx + 3'd1;
          prs_val    = '0;
          prs_digit  = 1'b0;
          prs_zero   = 1'b0;
        end
      end else begin
        prs_err = 1'b1;
      end
    end
    if (!last) return 1'b0;
    if (!prs_err && prs_idx == ipv4v_pkg::PortIdx && prs_digit &&
        prs_val <= ipv4v_pkg::PortMax)
      res = '{1'b1, prs_octets, prs_val[15:0]};
    prs_idx    = '0;
    prs_val    = '0;
    prs_digit  = 1'b0;
    prs_zero   = 1'b0;
    prs_err    = 1'b0;
    prs_octets = '0;
    return 1'b1;
  endfunction

  // one character through the input channel, with sender bursts and gaps
  task automatic send_char(input logic [7:0] c, input logic last, input bit typed,
                           input ipv4v_pkg::result_t want);
    int unsigned        gap;
    ipv4v_pkg::result_t res;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    char_code_i <= c;
    last_char_i <= last;
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    chars_sent++;
    if (parse_char(c, last, res)) pending_results.push_back(typed ? want : res);
  endtask

  task automatic send_text(input bit typed, input ipv4v_pkg::result_t want);
    foreach (text_chars[k])
      send_char(text_chars[k], k == text_chars.size() - 1, typed, want);
  endtask

  // hold the sender off until every expected word is out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  function automatic void push_num(input int unsigned v);
    logic [7:0] digits[$];
    do begin
      digits.push_front(ipv4v_pkg::CharZero + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digits[k]) text_chars.push_back(digits[k]);
  endfunction

  // extremes often, small values often, anything else otherwise
  function automatic int unsigned pick_value(input int unsigned hi);
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return hi;
      2:       return $urandom_range(0, 9);
      default: return $urandom_range(0, hi);
    endcase
  endfunction

  // a.b.c.d:p, with one part out of range when bad_part is 0..4
  function automatic void build_address(input int unsigned bad_part);
    for (int unsigned i = 0; i < 5; i++) begin
      if (i == bad_part)
        push_num(i < 4 ? $urandom_range(256, 99999) : $urandom_range(65536, 9999999));
      else
        push_num(pick_value(i < 4 ? 255 : 65535));
      if (i < 3) text_chars.push_back(ipv4v_pkg::CharDot);
      else if (i == 3) text_chars.push_back(ipv4v_pkg::CharColon);
    end
  endfunction

  function automatic logic [7:0] soup_char();
    case ($urandom_range(0, 19))
      0, 1, 2: return ipv4v_pkg::CharDot;
      3, 4, 5: return ipv4v_pkg::CharColon;
      6, 7:    return 8'($urandom_range(0, 255));
      default: return ipv4v_pkg::CharZero + 8'($urandom_range(0, 9));
    endcase
  endfunction

  function automatic void build_random_text();
    text_kind_e  kind;
    mutation_e   mut;
    int unsigned r;
    int unsigned pos;
    int unsigned len;
    text_chars.delete();
    r = $urandom_range(0, 99);
    if (r < 60) kind = TextClean;
    else if (r < 78) kind = TextMutated;
    else if (r < 86) kind = TextOverflow;
    else if (r < 95) kind = TextSoup;
    else kind = TextNoise;
    case (kind)
      TextClean:    build_address(5);
      TextOverflow: build_address($urandom_range(0, 4));
      TextMutated: begin
        build_address(5);
        mut = mutation_e'($urandom_range(0, 3));
        pos = $urandom_range(0, text_chars.size() - 1);
        case (mut)
          MutReplace: text_chars[pos] = 8'($urandom_range(0, 255));
          MutDelete:  text_chars.delete(pos);
          MutInsert:  text_chars.insert(pos, soup_char());
          default: begin
            // zero in front of the part after a separator, or of the first part
            while (pos < text_chars.size() && text_chars[pos] != ipv4v_pkg::CharDot &&
                   text_chars[pos] != ipv4v_pkg::CharColon) pos++;
            if (pos == text_chars.size()) text_chars.insert(0, ipv4v_pkg::CharZero);
            else text_chars.insert(pos + 1, ipv4v_pkg::CharZero);
          end
        endcase
      end
      TextSoup: begin
        len = $urandom_range(1, 12);
        repeat (len) text_chars.push_back(soup_char());
      end
      default: begin
        len = $urandom_range(1, 6);
        repeat (len) text_chars.push_back(8'($urandom_range(0, 255)));
      end
    endcase
  endfunction

  // receiver stall pattern
  initial begin : receiver_stalls
    stall_mode_e mode;
    int unsigned span;
    forever begin
      mode = stall_mode_e'($urandom_range(0, 3));
      span = (mode == StallAll) ? $urandom_range(1, 40) : $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk_i);
        case (mode)
          StallNone: out_stall_i <= 1'b0;
          StallHalf: out_stall_i <= ($urandom_range(0, 1) == 0);
          StallMost: out_stall_i <= ($urandom_range(0, 3) != 0);
          default:   out_stall_i <= 1'b1;
        endcase
      end
    end
  end

  // compare each accepted word with the oldest expectation
  always @(posedge clk_i) begin : check_results
    ipv4v_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word valid=%0b address=%h port=%0d", $time,
                 valid_res_o, address_o, port_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (valid_res_o !== want.ok) begin
          $display("%0t: valid expected %0b, got %0b", $time, want.ok, valid_res_o);
          mismatches++;
        end
        if (address_o !== want.address) begin
          $display("%0t: address expected %h, got %h", $time, want.address, address_o);
          mismatches++;
        end
        if (port_o !== want.port) begin
          $display("%0t: port expected %0d, got %0d", $time, want.port, port_o);
          mismatches++;
        end
      end
    end
  end

  // cycles with no word moving on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    bit          drained;
    int unsigned start_count;
    drained = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed texts
    foreach (text_cases[i]) begin
      text_chars.delete();
      for (int k = 0; k < text_cases[i].text.len(); k++)
        text_chars.push_back(text_cases[i].text[k]);
      send_text(text_cases[i].typed, text_cases[i].want);
    end
    drain_results();

    // random texts, mostly well formed
    start_count = chars_sent;
    while (chars_sent - start_count < RandomChars) begin
      build_random_text();
      send_text(1'b0, Rejected);
      if (!drained && chars_sent - start_count >= RandomChars / 2) begin
        drained = 1'b1;
        drain_results();
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

@@ ipv4_port_text_validator_core.f @@
hdl/ipv4v_pkg.sv
hdl/ipv4v_parser.sv
hdl/ipv4v_out_reg.sv
hdl/ipv4v_core_top.sv
bench/testbench.sv
